### sv/sacf_pkg.sv
// Shared types and constants for the set-associative cache tag store.
// No dependencies; imported by the channel interfaces and the top level.
package sacf_pkg;

  localparam int MAX_WAYS       = 4;
  localparam int MAX_INDEX_BITS = 10;
  localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
  localparam int ADDR_W         = 32;
  localparam int TAG_W          = 32;
  localparam int CNT_W          = 32;
  localparam int WAY_W          = $clog2(MAX_WAYS);
  localparam int SET_W          = MAX_INDEX_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK_MODE = 3'd4;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // statistics counter slots
  localparam int NUM_CNT  = 6;
  localparam int CNT_RHIT = 0;
  localparam int CNT_WHIT = 1;
  localparam int CNT_RMIS = 2;
  localparam int CNT_WMIS = 3;
  localparam int CNT_WB   = 4;
  localparam int CNT_WT   = 5;

  // one memory row holds a whole set
  typedef struct packed {
    logic [WAY_W-1:0]               ptr;
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0]            dirty;
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
  } set_row_t;

endpackage

### sv/sacf_req_if.sv
// Access request channel: valid/ready handshake with func and address.
// Depends on sacf_pkg.
interface sacf_req_if import sacf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] address;

  modport source (output valid, func, address, input ready);
  modport sink   (input valid, func, address, output ready);
endinterface

### sv/sacf_rsp_if.sv
// Access result channel: valid/ready handshake with hit flag and counters.
// Depends on sacf_pkg.
interface sacf_rsp_if import sacf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] read_hits;
  logic [CNT_W-1:0] write_hits;
  logic [CNT_W-1:0] read_misses;
  logic [CNT_W-1:0] write_misses;
  logic [CNT_W-1:0] writebacks;
  logic [CNT_W-1:0] writethroughs;

  modport source (output valid, hit, read_hits, write_hits, read_misses, write_misses,
                  writebacks, writethroughs, input ready);
  modport sink   (input valid, hit, read_hits, write_hits, read_misses, write_misses,
                  writebacks, writethroughs, output ready);
endinterface

### sv/set_assoc_cache_tag_fifo.sv
// Set-associative cache tag store with per-set FIFO replacement and saturating
// hit/miss/write-back/write-through counters. After reset the block clears its
// set memory and accepts no access (configuration writes are taken). Each access
// then reads the set's row from the single-port set memory on the request
// transfer; in the lookup state it compares all ways, writes the row back and
// loads the result register. A result waiting on the output does not block the
// next request transfer; the lookup of that request waits until the result leaves.
// Depends on sacf_pkg, sacf_req_if and sacf_rsp_if.
module set_assoc_cache_tag_fifo
  import sacf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sacf_req_if.sink              req,
  sacf_rsp_if.source            rsp
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOKUP} state_t;

  state_t           state;
  logic [SET_W-1:0] clr_cnt;

  // configuration
  logic [1:0] ways_log2;
  logic [4:0] offset_width;
  logic [3:0] index_width;
  logic       write_allocate;
  logic       write_back_mode;

  // latched request
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             write_q;

  // result register
  logic             out_valid;
  logic             hit_q;
  logic [CNT_W-1:0] cnt [NUM_CNT];

  // set memory
  set_row_t mem [NUM_SETS];
  set_row_t rd_row;
  set_row_t wr_row;
  logic     mem_we;
  logic [SET_W-1:0] mem_wa;

  // address split
  logic [3:0]        iw;
  logic [SET_W-1:0]  set_mask;
  logic [ADDR_W-1:0] addr_sh;
  logic [5:0]        tag_sh;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;
  logic              accept;

  always_comb begin
    iw       = (index_width > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_width;
    set_mask = ~({SET_W{1'b1}} << iw);
    addr_sh  = req.address >> offset_width;
    set_in   = addr_sh[SET_W-1:0] & set_mask;
    tag_sh   = 6'(offset_width) + 6'(iw);
    tag_in   = (tag_sh >= 6'd32) ? '0 : TAG_W'(req.address >> tag_sh[4:0]);
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // lookup and row update
  logic [WAY_W-1:0]    way_mask;
  logic [MAX_WAYS-1:0] hit_vec;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    victim;
  logic                fill;
  logic                evict_dirty;
  logic                go;
  logic [NUM_CNT-1:0]  inc;
  set_row_t            upd_row;

  always_comb begin
    case (ways_log2)
      2'd0:    way_mask = 2'd0;
      2'd1:    way_mask = 2'd1;
      default: way_mask = 2'd3;
    endcase
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = (WAY_W'(w) <= way_mask) && rd_row.valid[w] && (rd_row.tag[w] == tag_q);
    end
    hit     = |hit_vec;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
    end
    victim      = rd_row.ptr & way_mask;
    fill        = !hit && (!write_q || write_allocate);
    evict_dirty = fill && rd_row.valid[victim] && rd_row.dirty[victim];

    upd_row = rd_row;
    if (hit && write_q && write_back_mode) upd_row.dirty[hit_way] = 1'b1;
    if (fill) begin
      upd_row.valid[victim] = 1'b1;
      upd_row.tag[victim]   = tag_q;
      upd_row.dirty[victim] = write_q && write_back_mode;
      upd_row.ptr           = (victim + 1'b1) & way_mask;
    end

    inc           = '0;
    inc[CNT_RHIT] = hit && !write_q;
    inc[CNT_WHIT] = hit && write_q;
    inc[CNT_RMIS] = !hit && !write_q;
    inc[CNT_WMIS] = !hit && write_q;
    inc[CNT_WB]   = evict_dirty;
    inc[CNT_WT]   = write_q && !write_back_mode;
  end

  assign go     = (state == S_LOOKUP) && (!out_valid || rsp.ready);
  assign mem_we = (state == S_CLEAR) || go;
  assign mem_wa = (state == S_CLEAR) ? clr_cnt : set_q;
  assign wr_row = (state == S_CLEAR) ? '0 : upd_row;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= wr_row;
    if (accept) rd_row <= mem[set_in];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q   <= set_in;
      tag_q   <= tag_in;
      write_q <= (req.func == FUNC_WRITE);
    end
    if (go) hit_q <= hit;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_log2       <= 2'd0;
      offset_width    <= 5'd4;
      index_width     <= 4'd4;
      write_allocate  <= 1'b1;
      write_back_mode <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == CFG_WAYS_LOG2)       ways_log2       <= cfg_data[1:0];
      if (cfg_index == CFG_OFFSET_WIDTH)    offset_width    <= cfg_data[4:0];
      if (cfg_index == CFG_INDEX_WIDTH)     index_width     <= cfg_data[3:0];
      if (cfg_index == CFG_WRITE_ALLOCATE)  write_allocate  <= cfg_data[0];
      if (cfg_index == CFG_WRITE_BACK_MODE) write_back_mode <= cfg_data[0];
    end
  end

  // control state, result valid and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) cnt[i] <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SET_W'(NUM_SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          if (go) begin
            state <= S_IDLE;
            for (int i = 0; i < NUM_CNT; i++) begin
              if (inc[i] && (cnt[i] != {CNT_W{1'b1}})) cnt[i] <= cnt[i] + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.hit           = hit_q;
  assign rsp.read_hits     = cnt[CNT_RHIT];
  assign rsp.write_hits    = cnt[CNT_WHIT];
  assign rsp.read_misses   = cnt[CNT_RMIS];
  assign rsp.write_misses  = cnt[CNT_WMIS];
  assign rsp.writebacks    = cnt[CNT_WB];
  assign rsp.writethroughs = cnt[CNT_WT];

  // a request transfer always leads into a lookup
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOKUP))
    else $error("request transfer not followed by lookup");

  // a new result only appears after a lookup cycle
  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_LOOKUP))
    else $error("result appeared without a lookup");

  // the row write of a lookup never overruns a waiting result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_LOOKUP)) |-> (!out_valid || rsp.ready))
    else $error("lookup committed while result stalled");

  // saturating counters never go down
  a_rhit_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt[CNT_RHIT] >= $past(cnt[CNT_RHIT])))
    else $error("read hit counter decreased");

  a_wb_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt[CNT_WB] >= $past(cnt[CNT_WB])))
    else $error("writeback counter decreased");

endmodule
